// ===== src/bopp_pkg.sv =====
package bopp_pkg;

   // Sizes of the parse stack and of the variable space.
   localparam int STACK_DEPTH = 32;
   localparam int VAR_COUNT   = 1024;
   localparam int MAX_CMDS    = 32;

   localparam int SP_W    = $clog2(STACK_DEPTH + 1);
   localparam int ADDR_W  = $clog2(STACK_DEPTH);
   localparam int CNT_W   = $clog2(MAX_CMDS + 1);
   localparam int STEP_W  = 3;

   // Fixed field widths of the channels.
   localparam int CMD_W    = 4;
   localparam int VAR_W    = 10;
   localparam int OP_W     = 3;
   localparam int STATUS_W = 2;
   localparam int KIND_W   = 4;
   localparam int CLASS_W  = 3;

   typedef logic [KIND_W-1:0]  kind_type;
   typedef logic [CLASS_W-1:0] class_type;

   // Token kinds, plus the stack-only markers.
   localparam kind_type KIND_XOR    = 4'd0;
   localparam kind_type KIND_OR     = 4'd1;
   localparam kind_type KIND_AND    = 4'd2;
   localparam kind_type KIND_NOT    = 4'd3;
   localparam kind_type KIND_LPAREN = 4'd4;
   localparam kind_type KIND_RPAREN = 4'd5;
   localparam kind_type KIND_VAR    = 4'd6;
   localparam kind_type KIND_FALSE  = 4'd7;
   localparam kind_type KIND_TRUE   = 4'd8;
   localparam kind_type KIND_END    = 4'd9;
   localparam kind_type KIND_BOTTOM = 4'd9;
   localparam kind_type KIND_LT     = 4'd10;
   localparam kind_type KIND_EXPR   = 4'd11;

   // Precedence table classes.
   localparam class_type CL_XOR    = 3'd0;
   localparam class_type CL_OR     = 3'd1;
   localparam class_type CL_AND    = 3'd2;
   localparam class_type CL_NOT    = 3'd3;
   localparam class_type CL_LPAREN = 3'd4;
   localparam class_type CL_RPAREN = 3'd5;
   localparam class_type CL_OPND   = 3'd6;
   localparam class_type CL_END    = 3'd7;

   // Postfix command codes.
   localparam logic [OP_W-1:0] OP_NONE  = 3'd0;
   localparam logic [OP_W-1:0] OP_FALSE = 3'd1;
   localparam logic [OP_W-1:0] OP_TRUE  = 3'd2;
   localparam logic [OP_W-1:0] OP_VAR   = 3'd3;
   localparam logic [OP_W-1:0] OP_NOT   = 3'd4;
   localparam logic [OP_W-1:0] OP_AND   = 3'd5;
   localparam logic [OP_W-1:0] OP_OR    = 3'd6;
   localparam logic [OP_W-1:0] OP_XOR   = 3'd7;

   // Status codes.
   localparam logic [STATUS_W-1:0] ST_BUSY  = 2'd0;
   localparam logic [STATUS_W-1:0] ST_DONE  = 2'd1;
   localparam logic [STATUS_W-1:0] ST_ERROR = 2'd2;

   typedef struct packed {
      kind_type          kind;
      logic [VAR_W-1:0]  vnum;
   } entry_type;

   localparam entry_type BOTTOM_ENTRY = '{kind: KIND_BOTTOM, vnum: '0};
   localparam entry_type LT_ENTRY     = '{kind: KIND_LT,     vnum: '0};
   localparam entry_type EXPR_ENTRY   = '{kind: KIND_EXPR,   vnum: '0};

   typedef struct packed {
      logic      ok;
      class_type cls;
   } class_res_type;

   typedef enum logic [2:0] {
      REL_LT, REL_EQ, REL_GT, REL_INV, REL_EOF
   } rel_type;

   typedef enum logic [1:0] {
      RED_OPND, RED_RPAR, RED_NOT, RED_BIN
   } red_type;

   typedef enum logic [2:0] {
      STEP_POP_ANY, STEP_POP_EXPR, STEP_POP_LPAR, STEP_POP_LT, STEP_EMIT, STEP_DONE
   } step_type;

   function automatic class_res_type class_of(kind_type k);
      class_res_type r;
      r.ok  = 1'b1;
      r.cls = CL_END;
      if (k <= KIND_RPAREN) begin
         r.cls = k[CLASS_W-1:0];
      end else if (k <= KIND_TRUE) begin
         r.cls = CL_OPND;
      end else if (k != KIND_BOTTOM) begin
         r.ok = 1'b0;
      end
      return r;
   endfunction

   function automatic rel_type prec_rel(class_type row, class_type col);
      rel_type r;
      unique case (row)
         CL_XOR, CL_OR, CL_AND, CL_NOT: begin
            r = (col == CL_NOT || col == CL_LPAREN || col == CL_OPND) ? REL_LT : REL_GT;
         end
         CL_LPAREN: begin
            if (col == CL_RPAREN)   r = REL_EQ;
            else if (col == CL_END) r = REL_INV;
            else                    r = REL_LT;
         end
         CL_RPAREN, CL_OPND: begin
            r = (col == CL_LPAREN || col == CL_OPND) ? REL_INV : REL_GT;
         end
         default: begin
            if (col == CL_RPAREN)   r = REL_INV;
            else if (col == CL_END) r = REL_EOF;
            else                    r = REL_LT;
         end
      endcase
      return r;
   endfunction

   function automatic logic [OP_W-1:0] op_of_kind(kind_type k);
      logic [OP_W-1:0] op;
      unique case (k)
         KIND_XOR:   op = OP_XOR;
         KIND_OR:    op = OP_OR;
         KIND_AND:   op = OP_AND;
         KIND_NOT:   op = OP_NOT;
         KIND_VAR:   op = OP_VAR;
         KIND_FALSE: op = OP_FALSE;
         KIND_TRUE:  op = OP_TRUE;
         default:    op = OP_NONE;
      endcase
      return op;
   endfunction

   function automatic red_type red_of(kind_type k);
      red_type r;
      if (k == KIND_VAR || k == KIND_FALSE || k == KIND_TRUE) r = RED_OPND;
      else if (k == KIND_RPAREN)                              r = RED_RPAR;
      else if (k == KIND_NOT)                                 r = RED_NOT;
      else                                                    r = RED_BIN;
      return r;
   endfunction

   // Micro-program of each handle reduction: each step pops one stack entry or emits one command.
   function automatic step_type red_step(red_type r, logic [STEP_W-1:0] idx);
      step_type s;
      s = STEP_DONE;
      unique case (r)
         RED_OPND: begin
            if (idx == 3'd0)      s = STEP_POP_ANY;
            else if (idx == 3'd1) s = STEP_POP_LT;
            else if (idx == 3'd2) s = STEP_EMIT;
         end
         RED_RPAR: begin
            if (idx == 3'd0)      s = STEP_POP_ANY;
            else if (idx == 3'd1) s = STEP_POP_EXPR;
            else if (idx == 3'd2) s = STEP_POP_LPAR;
            else if (idx == 3'd3) s = STEP_POP_LT;
         end
         RED_NOT: begin
            if (idx == 3'd0)      s = STEP_POP_EXPR;
            else if (idx == 3'd1) s = STEP_POP_ANY;
            else if (idx == 3'd2) s = STEP_EMIT;
            else if (idx == 3'd3) s = STEP_POP_LT;
         end
         default: begin
            if (idx == 3'd0)      s = STEP_POP_EXPR;
            else if (idx == 3'd1) s = STEP_POP_ANY;
            else if (idx == 3'd2) s = STEP_EMIT;
            else if (idx == 3'd3) s = STEP_POP_EXPR;
            else if (idx == 3'd4) s = STEP_POP_LT;
         end
      endcase
      return s;
   endfunction

endpackage

// ===== src/bopp_channels.sv =====
interface bopp_req_if
   import bopp_pkg::*;
   ();
   logic             valid;
   logic             ready;
   logic [CMD_W-1:0] cmd;
   logic [VAR_W-1:0] var_index;

   modport source (output valid, output cmd, output var_index, input ready);
   modport sink   (input valid, input cmd, input var_index, output ready);
endinterface

interface bopp_rsp_if
   import bopp_pkg::*;
   ();
   logic                valid;
   logic                ready;
   logic [OP_W-1:0]     out_op;
   logic [VAR_W-1:0]    out_var;
   logic [STATUS_W-1:0] status;
   logic                last;

   modport source (output valid, output out_op, output out_var, output status,
                   output last, input ready);
   modport sink   (input valid, input out_op, input out_var, input status,
                   input last, output ready);
endinterface

// ===== src/boolean_operator_precedence_parser_unit.sv =====
// Operator-precedence parser for Boolean formulas, one token per request transaction.
// The req_bus channel carries one token (cmd, var_index) per transaction. For each
// token the rsp_bus channel returns zero or more postfix command transactions
// (out_op, out_var, last low) followed by exactly one status transaction with last
// high: still parsing, formula complete and valid, or error. Once an error is seen,
// every later token returns only an error status until an end token, after whose
// status the parser restarts with an empty stack.
// The token is taken only while the parser is idle; the parser then walks a
// stack memory with one write port and one registered read port. Each handle
// reduction adds its pops (each a read and a check), its commands, the closing
// of the handle, the push of the expression marker and a re-read of the top.
// The next token is accepted in the cycle after the status is loaded, even while
// that status still waits in the output register.
// When the receiver stalls, the output register holds its transaction and the
// sequencer waits at the next command or status it has to send.
// Synchronous reset leaves the stack holding only its bottom marker, clears the
// error flag and empties the output register.
module boolean_operator_precedence_parser_unit
   import bopp_pkg::*;
   (
   input  logic      clock,
   input  logic      reset,
   bopp_req_if.sink   req_bus,
   bopp_rsp_if.source rsp_bus
   );

   typedef enum logic [3:0] {
      S_IDLE, S_TOP, S_TOP_CHK, S_TT_CHK, S_RED, S_POP_CHK,
      S_PUSH_LT, S_PUSH_TOP, S_PUSH_TOK, S_PUSH_EXPR, S_STATUS
   } state_type;

   state_type state_ff, state_in;
   logic [SP_W-1:0]     sp_ff, sp_in;
   logic                error_ff, error_in;
   logic [CNT_W-1:0]    cmd_count_ff, cmd_count_in;
   entry_type           tok_ff, tok_in;
   logic                end_ff, end_in;
   class_type           col_ff, col_in;
   entry_type           top_ff, top_in;
   logic                nonterm_ff, nonterm_in;
   red_type             red_ff, red_in;
   logic [STEP_W-1:0]   step_ff, step_in;
   entry_type           t_ff, t_in;
   logic [STATUS_W-1:0] st_ff, st_in;

   logic                rsp_valid_ff, rsp_valid_in;
   logic [OP_W-1:0]     rsp_op_ff, rsp_op_in;
   logic [VAR_W-1:0]    rsp_var_ff, rsp_var_in;
   logic [STATUS_W-1:0] rsp_status_ff, rsp_status_in;
   logic                rsp_last_ff, rsp_last_in;

   // Parse stack memory. Entry zero always reads as the bottom marker: it is
   // only ever overwritten after an error, when its contents no longer matter.
   entry_type           stack_mem [STACK_DEPTH];
   entry_type           rd_data_ff;
   logic                rd_zero_ff;
   logic [ADDR_W-1:0]   rd_addr;
   logic                wr_en;
   logic [ADDR_W-1:0]   wr_addr;
   entry_type           wr_data;

   entry_type           rdv;
   entry_type           top_sel;
   class_res_type       tt_cls;
   class_res_type       req_cls;
   rel_type             rel;
   step_type            step_code;
   logic [SP_W-1:0]     sp_dec;
   logic [SP_W-1:0]     sp_dec2;
   logic                out_free;
   logic                push_ok;
   logic                pop_ok;

   assign rdv       = rd_zero_ff ? BOTTOM_ENTRY : rd_data_ff;
   assign top_sel   = (state_ff == S_TOP_CHK) ? rdv : top_ff;
   assign tt_cls    = class_of(rdv.kind);
   assign req_cls   = class_of(req_bus.cmd);
   assign rel       = prec_rel(tt_cls.cls, col_ff);
   assign step_code = red_step(red_ff, step_ff);
   assign sp_dec    = sp_ff - SP_W'(1);
   assign sp_dec2   = sp_ff - SP_W'(2);
   assign out_free  = !rsp_valid_ff || rsp_bus.ready;
   assign push_ok   = sp_ff < SP_W'(STACK_DEPTH);

   always_comb begin
      unique case (step_code)
         STEP_POP_EXPR: pop_ok = (rdv.kind == KIND_EXPR);
         STEP_POP_LPAR: pop_ok = (rdv.kind == KIND_LPAREN);
         STEP_POP_LT:   pop_ok = (rdv.kind == KIND_LT);
         default:       pop_ok = 1'b1;
      endcase
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         stack_mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= stack_mem[rd_addr];
      rd_zero_ff <= (rd_addr == '0);
   end

   assign req_bus.ready  = (state_ff == S_IDLE);
   assign rsp_bus.valid  = rsp_valid_ff;
   assign rsp_bus.out_op = rsp_op_ff;
   assign rsp_bus.out_var = rsp_var_ff;
   assign rsp_bus.status = rsp_status_ff;
   assign rsp_bus.last   = rsp_last_ff;

   always_comb begin
      logic do_eval;
      logic fail;

      do_eval       = 1'b0;
      fail          = 1'b0;
      state_in      = state_ff;
      sp_in         = sp_ff;
      error_in      = error_ff;
      cmd_count_in  = cmd_count_ff;
      tok_in        = tok_ff;
      end_in        = end_ff;
      col_in        = col_ff;
      top_in        = top_ff;
      nonterm_in    = nonterm_ff;
      red_in        = red_ff;
      step_in       = step_ff;
      t_in          = t_ff;
      st_in         = st_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_op_in     = rsp_op_ff;
      rsp_var_in    = rsp_var_ff;
      rsp_status_in = rsp_status_ff;
      rsp_last_in   = rsp_last_ff;
      rd_addr       = sp_dec[ADDR_W-1:0];
      wr_en         = 1'b0;
      wr_addr       = sp_ff[ADDR_W-1:0];
      wr_data       = tok_ff;

      if (rsp_valid_ff && rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_bus.valid) begin
               tok_in.kind  = req_bus.cmd;
               tok_in.vnum  = (req_bus.cmd == KIND_VAR) ? req_bus.var_index : '0;
               end_in       = (req_bus.cmd == KIND_END);
               col_in       = req_cls.cls;
               cmd_count_in = '0;
               // A sticky error, an unknown token or an out-of-range variable
               // goes straight to the error status.
               if (error_ff || req_bus.cmd > KIND_END ||
                   (req_bus.cmd == KIND_VAR && 32'(req_bus.var_index) >= VAR_COUNT)) begin
                  st_in    = ST_ERROR;
                  state_in = S_STATUS;
               end else begin
                  state_in = S_TOP;
               end
            end
         end
         S_TOP: begin
            if (sp_ff == '0) begin
               fail = 1'b1;
            end else begin
               state_in = S_TOP_CHK;
            end
         end
         S_TOP_CHK: begin
            top_in = rdv;
            if (rdv.kind > KIND_BOTTOM) begin
               // The top is a marker: the terminal to compare lies one below.
               nonterm_in = 1'b1;
               if (sp_ff < SP_W'(2)) begin
                  fail = 1'b1;
               end else begin
                  rd_addr  = sp_dec2[ADDR_W-1:0];
                  state_in = S_TT_CHK;
               end
            end else begin
               nonterm_in = 1'b0;
               do_eval    = 1'b1;
            end
         end
         S_TT_CHK: begin
            do_eval = 1'b1;
         end
         S_RED: begin
            unique case (step_code)
               STEP_EMIT: begin
                  if (out_free) begin
                     rsp_valid_in  = 1'b1;
                     rsp_op_in     = op_of_kind(t_ff.kind);
                     rsp_var_in    = (t_ff.kind == KIND_VAR) ? t_ff.vnum : '0;
                     rsp_status_in = ST_BUSY;
                     rsp_last_in   = 1'b0;
                     cmd_count_in  = cmd_count_ff + CNT_W'(1);
                     step_in       = step_ff + STEP_W'(1);
                  end
               end
               STEP_DONE: begin
                  state_in = S_PUSH_EXPR;
               end
               default: begin
                  if (sp_ff == '0) begin
                     fail = 1'b1;
                  end else begin
                     sp_in    = sp_dec;
                     state_in = S_POP_CHK;
                  end
               end
            endcase
         end
         S_POP_CHK: begin
            if (step_code == STEP_POP_ANY) begin
               t_in = rdv;
            end
            if (pop_ok) begin
               step_in  = step_ff + STEP_W'(1);
               state_in = S_RED;
            end else begin
               fail = 1'b1;
            end
         end
         S_PUSH_LT, S_PUSH_TOP, S_PUSH_TOK, S_PUSH_EXPR: begin
            if (!push_ok) begin
               fail = 1'b1;
            end else begin
               wr_en = 1'b1;
               sp_in = sp_ff + SP_W'(1);
               unique case (state_ff)
                  S_PUSH_LT: begin
                     wr_data  = LT_ENTRY;
                     state_in = nonterm_ff ? S_PUSH_TOP : S_PUSH_TOK;
                  end
                  S_PUSH_TOP: begin
                     wr_data  = top_ff;
                     state_in = S_PUSH_TOK;
                  end
                  S_PUSH_TOK: begin
                     wr_data  = tok_ff;
                     st_in    = ST_BUSY;
                     state_in = S_STATUS;
                  end
                  default: begin
                     wr_data  = EXPR_ENTRY;
                     state_in = S_TOP;
                  end
               endcase
            end
         end
         default: begin
            // Status transaction closes the token; an end token restarts the parse.
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_op_in     = OP_NONE;
               rsp_var_in    = '0;
               rsp_status_in = st_ff;
               rsp_last_in   = 1'b1;
               if (end_ff) begin
                  sp_in    = SP_W'(1);
                  error_in = 1'b0;
               end else if (st_ff == ST_ERROR) begin
                  error_in = 1'b1;
               end
               state_in = S_IDLE;
            end
         end
      endcase

      if (do_eval) begin
         if (!tt_cls.ok) begin
            fail = 1'b1;
         end else begin
            unique case (rel)
               REL_LT: begin
                  // A marker on top is lifted so that the shift marker goes below it.
                  if (top_sel.kind > KIND_BOTTOM) begin
                     sp_in = sp_dec;
                  end
                  state_in = S_PUSH_LT;
               end
               REL_EQ: begin
                  state_in = S_PUSH_TOK;
               end
               REL_EOF: begin
                  st_in    = (top_sel.kind == KIND_EXPR) ? ST_DONE : ST_ERROR;
                  state_in = S_STATUS;
               end
               REL_GT: begin
                  if (cmd_count_ff >= CNT_W'(MAX_CMDS)) begin
                     fail = 1'b1;
                  end else begin
                     red_in   = red_of(rdv.kind);
                     step_in  = '0;
                     state_in = S_RED;
                  end
               end
               default: begin
                  fail = 1'b1;
               end
            endcase
         end
      end

      if (fail) begin
         st_in    = ST_ERROR;
         state_in = S_STATUS;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         sp_ff        <= SP_W'(1);
         error_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sp_ff        <= sp_in;
         error_ff     <= error_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cmd_count_ff  <= cmd_count_in;
      tok_ff        <= tok_in;
      end_ff        <= end_in;
      col_ff        <= col_in;
      top_ff        <= top_in;
      nonterm_ff    <= nonterm_in;
      red_ff        <= red_in;
      step_ff       <= step_in;
      t_ff          <= t_in;
      st_ff         <= st_in;
      rsp_op_ff     <= rsp_op_in;
      rsp_var_ff    <= rsp_var_in;
      rsp_status_ff <= rsp_status_in;
      rsp_last_ff   <= rsp_last_in;
   end

   // A stack write never lands beyond the last entry.
   assert property (@(posedge clock) disable iff (reset)
      wr_en |-> sp_ff < SP_W'(STACK_DEPTH))
      else $error("stack write past the last entry");

   // A token arriving under a sticky error goes straight to its status.
   assert property (@(posedge clock) disable iff (reset)
      (req_bus.valid && req_bus.ready && error_ff) |=> state_ff == S_STATUS)
      else $error("token processed while the error flag is set");

   // A command is emitted only while the per-token command budget lasts.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_RED && cmd_count_in != cmd_count_ff) |->
         cmd_count_ff < CNT_W'(MAX_CMDS))
      else $error("more commands than allowed for one token");

   // The status of an end token leaves a fresh parser behind.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_STATUS && out_free && end_ff) |=>
         (sp_ff == SP_W'(1) && !error_ff && state_ff == S_IDLE))
      else $error("parser did not restart after an end token");

endmodule
